[hw/rtl/contiguous_block_allocator_macros.svh]
// assertion macros for the contiguous block allocator
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// checked property, held off while reset is low
`define CBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cba assertion failed");
// checked property, also active during reset
`define CBA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cba assertion failed");
`else
`define CBA_ASSERT(lbl, prop)
`define CBA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[hw/rtl/cba_pkg.sv]
// types and constants shared by the contiguous block allocator
`default_nettype none

package cba_pkg;

  localparam int MAP_BYTES = 512;
  localparam int MAP_AW    = $clog2(MAP_BYTES);
  localparam int BLK_W     = MAP_AW + 3;
  localparam int MAP_BLKS  = MAP_BYTES * 8;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int SIZE_W    = 22;
  localparam int NEED_W    = SIZE_W - 9 + 1;
  localparam int BN_W      = ((BLK_W + 1) > CFG_W) ? (BLK_W + 1) : CFG_W;
  localparam int END_W     = ((BN_W > NEED_W) ? BN_W : NEED_W) + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT      = 1'd1;

  localparam logic [CFG_W-1:0] FIRST_DATA_BLOCK_RST = 13'd6;
  localparam logic [CFG_W-1:0] BLOCK_COUNT_RST      = 13'd4096;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [SIZE_W-1:0] size_bytes;
    logic [8:0]        byte_index;
    logic [7:0]        byte_value;
  } cba_req_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] base_blk;
    logic [7:0]  read_byte;
  } cba_res_t;

  // sequencer to run unit
  typedef struct packed {
    logic clear;
    logic step;
  } cba_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/contiguous_block_allocator.sv]
// top level of the first-fit contiguous block allocator
// usage
//   in_valid/in_stall/in_data carry one request word: allocate a run, load a
//   bitmap byte or read a bitmap byte. out_valid/out_stall/out_data return
//   exactly one result word per request. cfg_valid/cfg_ready/cfg_index/
//   cfg_data write the first data block (index 0) and the block count
//   (index 1); cfg_ready is always high, write only while the block is idle.
// operation
//   load: the byte is written when the request is taken. read: one ram read.
//   allocate: a scan for a free run and, if one is found, a read-modify-write
//   of its bytes; the scan reads one bitmap byte per cycle from the single
//   ram read port. zero length or an empty scan window skip both steps.
//   one request is worked on at a time; in_stall is high while busy.
// reset
//   rst_n is synchronous, active low. afterwards a clearing pass zeroes the
//   bitmap ram, one byte per cycle, all 512 bytes, with in_stall held high.
// backpressure
//   the result sits in an output register and holds while out_stall is high;
//   the next request is still taken, its result waits in the sequencer
`default_nettype none

`include "contiguous_block_allocator_macros.svh"

module contiguous_block_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire cba_pkg::cba_req_t             in_data,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output cba_pkg::cba_res_t                  out_data,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cba_pkg::CFG_W-1:0]     cfg_data
);
  import cba_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_CLR   = 3'd0;  // clearing pass after reset
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RDW   = 3'd2;  // waiting on a byte read
  localparam logic [2:0] ST_SCAN  = 3'd3;  // searching for a free run
  localparam logic [2:0] ST_MARK0 = 3'd4;  // set up marking pointer
  localparam logic [2:0] ST_MARK  = 3'd5;  // read-modify-write of run bytes
  localparam logic [2:0] ST_FIN   = 3'd6;  // hand result to output register

  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  cfg_first_r, cfg_count_r;
  logic [MAP_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [MAP_AW:0]   ptr_r, ptr_nxt;       // next byte to read
  logic [MAP_AW-1:0] cur_r, cur_nxt;       // byte whose data is on ram_rdata
  logic              dv_r, dv_nxt;         // ram_rdata holds a wanted byte
  logic [NEED_W-1:0] need_r, need_nxt;
  cba_res_t          res_r, res_nxt;
  cba_res_t          out_r;
  logic              out_valid_r;

  logic              in_acc;
  logic              out_load;
  logic [NEED_W-1:0] need_in;
  logic [BN_W-1:0]   first_blk, limit_blk, lim_m1;
  logic [MAP_AW-1:0] last_byte;
  logic              idx_ok;
  logic              issue;

  // ram port signals
  logic              ram_we;
  logic [MAP_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // run unit
  cba_ctl_t          ctl;
  logic              found;
  logic [BN_W-1:0]   start_blk;
  logic [7:0]        mask;
  logic [MAP_AW-1:0] mark_first, mark_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // blocks to allocate, size rounded up to 512 bytes
  assign need_in = NEED_W'(in_data.size_bytes[SIZE_W-1:9])
                 + NEED_W'(in_data.size_bytes[8:0] != '0);

  // scan window, the count is capped to what the bitmap can hold
  assign first_blk = BN_W'(cfg_first_r);
  assign limit_blk = (BN_W'(cfg_count_r) > BN_W'(MAP_BLKS)) ? BN_W'(MAP_BLKS)
                                                            : BN_W'(cfg_count_r);
  assign lim_m1    = BN_W'(limit_blk - 1'b1);
  assign last_byte = lim_m1[MAP_AW+2:3];
  assign idx_ok    = 32'(in_data.byte_index) < MAP_BYTES;

  // one read per cycle while the pointer is inside the range
  assign issue = (state_r == ST_SCAN) ? (ptr_r <= {1'b0, last_byte})
                                      : (ptr_r <= {1'b0, mark_last});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_first_r <= FIRST_DATA_BLOCK_RST;
      cfg_count_r <= BLOCK_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_DATA_BLOCK: cfg_first_r <= cfg_data;
        CFG_BLOCK_COUNT:      cfg_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    ptr_nxt      = ptr_r;
    cur_nxt      = cur_r;
    dv_nxt       = 1'b0;
    need_nxt     = need_r;
    res_nxt      = res_r;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cur_r;
    ram_wdata    = ram_rdata | mask;
    ram_raddr    = ptr_r[MAP_AW-1:0];
    ctl.clear    = 1'b0;
    ctl.step     = 1'b0;

    case (state_r)
      ST_CLR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = MAP_AW'(clr_addr_r + 1'b1);
        if (clr_addr_r == MAP_AW'(MAP_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        ram_raddr = MAP_AW'(in_data.byte_index);
        if (in_acc) begin
          res_nxt   = '0;
          ctl.clear = 1'b1;
          need_nxt  = need_in;
          state_nxt = ST_FIN;
          case (in_data.operation)
            OP_ALLOC: begin
              if (need_in == '0) begin
                res_nxt.ok = 1'b1;
              end else if (first_blk < limit_blk) begin
                ptr_nxt   = first_blk[MAP_AW+3:3];
                state_nxt = ST_SCAN;
              end
            end
            OP_LOAD: begin
              if (idx_ok) begin
                ram_we     = 1'b1;
                ram_waddr  = MAP_AW'(in_data.byte_index);
                ram_wdata  = in_data.byte_value;
                res_nxt.ok = 1'b1;
              end
            end
            OP_READ: begin
              if (idx_ok) begin
                state_nxt = ST_RDW;
              end
            end
            default: ;
          endcase
        end
      end

      ST_RDW: begin
        res_nxt.ok        = 1'b1;
        res_nxt.read_byte = ram_rdata;
        state_nxt         = ST_FIN;
      end

      ST_SCAN: begin
        if (issue) begin
          ptr_nxt = ptr_r + 1'b1;
          cur_nxt = ptr_r[MAP_AW-1:0];
          dv_nxt  = 1'b1;
        end
        if (dv_r) begin
          ctl.step = 1'b1;
          if (found) begin
            dv_nxt    = 1'b0;
            state_nxt = ST_MARK0;
          end else if (cur_r == last_byte) begin
            dv_nxt    = 1'b0;
            state_nxt = ST_FIN;
          end
        end
      end

      ST_MARK0: begin
        ptr_nxt   = {1'b0, mark_first};
        state_nxt = ST_MARK;
      end

      ST_MARK: begin
        if (issue) begin
          ptr_nxt = ptr_r + 1'b1;
          cur_nxt = ptr_r[MAP_AW-1:0];
          dv_nxt  = 1'b1;
        end
        // write back the byte read last cycle with the run bits set
        if (dv_r) begin
          ram_we = 1'b1;
          if (cur_r == mark_last) begin
            dv_nxt           = 1'b0;
            res_nxt.ok       = 1'b1;
            res_nxt.base_blk = 12'(start_blk);
            state_nxt        = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      ptr_r       <= '0;
      cur_r       <= '0;
      dv_r        <= 1'b0;
      need_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      ptr_r      <= ptr_nxt;
      cur_r      <= cur_nxt;
      dv_r       <= dv_nxt;
      need_r     <= need_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  cba_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cba_run_unit u_run (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .byte_no    (cur_r),
    .byte_data  (ram_rdata),
    .first_blk  (first_blk),
    .limit_blk  (limit_blk),
    .need       (need_r),
    .found      (found),
    .start_blk  (start_blk),
    .mask       (mask),
    .mark_first (mark_first),
    .mark_last  (mark_last)
  );

  // the search only reads the bitmap
  `CBA_ASSERT(a_scan_no_write, (state_r == ST_SCAN) |-> !ram_we)
  // marking only follows a nonzero request
  `CBA_ASSERT(a_mark_need, (state_r == ST_MARK || state_r == ST_MARK0) |-> (need_r != '0))
  // a failed result carries no start and no byte
  `CBA_ASSERT(a_fail_zero,
    (state_r == ST_FIN && !res_r.ok) |-> (res_r.base_blk == '0 && res_r.read_byte == '0))
  // a held result is not overwritten by the next one
  `CBA_ASSERT(a_out_hold, (out_valid_r && out_stall) |=> $stable(out_r))
  // reset always restarts the clearing pass
  `CBA_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (state_r == ST_CLR && in_stall))

endmodule

`default_nettype wire

[hw/rtl/cba_ram.sv]
// generic single write, single read ram with registered read data
`default_nettype none

module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/cba_run_unit.sv]
// free run tracker: walks one bitmap byte per step, builds marking masks
`default_nettype none

module cba_run_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cba_pkg::cba_ctl_t        ctl,
  input  wire logic [cba_pkg::MAP_AW-1:0] byte_no,
  input  wire logic [7:0]               byte_data,
  input  wire logic [cba_pkg::BN_W-1:0] first_blk,
  input  wire logic [cba_pkg::BN_W-1:0] limit_blk,
  input  wire logic [cba_pkg::NEED_W-1:0] need,
  output logic                          found,
  output logic [cba_pkg::BN_W-1:0]      start_blk,
  output logic [7:0]                    mask,
  output logic [cba_pkg::MAP_AW-1:0]    mark_first,
  output logic [cba_pkg::MAP_AW-1:0]    mark_last
);
  import cba_pkg::*;

  logic [NEED_W-1:0] run_r, run_nxt;
  logic [BN_W-1:0]   start_r, start_nxt;
  logic [END_W-1:0]  end_blk;
  logic [END_W-1:0]  end_m1;

  // eight bit positions of the byte, in block order
  always_comb begin
    logic [BN_W-1:0] blk;
    logic            fnd;
    run_nxt   = run_r;
    start_nxt = start_r;
    fnd       = 1'b0;
    for (int k = 0; k < 8; k++) begin
      blk = BN_W'({byte_no, 3'(k)});
      if (!fnd && blk >= first_blk && blk < limit_blk) begin
        if (byte_data[k]) begin
          run_nxt = '0;
        end else begin
          if (run_nxt == '0) begin
            start_nxt = blk;
          end
          run_nxt = NEED_W'(run_nxt + 1'b1);
          if (run_nxt == need) begin
            fnd = 1'b1;
          end
        end
      end
    end
    found = fnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      run_r   <= '0;
      start_r <= '0;
    end else if (ctl.step) begin
      run_r   <= run_nxt;
      start_r <= start_nxt;
    end
  end

  assign end_blk = END_W'(start_r) + END_W'(need);
  assign end_m1  = END_W'(end_blk - 1'b1);

  // bits of the current byte that fall inside the found run
  always_comb begin
    logic [END_W-1:0] blk;
    for (int k = 0; k < 8; k++) begin
      blk     = END_W'({byte_no, 3'(k)});
      mask[k] = (blk >= END_W'(start_r)) && (blk < end_blk);
    end
  end

  assign start_blk  = start_r;
  assign mark_first = start_r[MAP_AW+2:3];
  assign mark_last  = end_m1[MAP_AW+2:3];

endmodule

`default_nettype wire
